>>> rtl/core/direction_to_azimuth_zenith_core_macros.svh
// ----------------------------------------------------------------------------
// direction_to_azimuth_zenith_core assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef DIRECTION_TO_AZIMUTH_ZENITH_CORE_MACROS_SVH
`define DIRECTION_TO_AZIMUTH_ZENITH_CORE_MACROS_SVH

// same-cycle implication
`define DTAZ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTAZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dtaz_pkg.sv
// ----------------------------------------------------------------------------
// dtaz_pkg
// constants, microcode format and tables for the azimuth/zenith core
// ----------------------------------------------------------------------------
`default_nettype none

package dtaz_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 16;
    localparam int LOOP1_LAST   =
        ((CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS) - 1;
    localparam int GUARD        = 8;

    localparam int PCW   = 4;
    localparam int IW    = 5;
    localparam int INW   = 16;
    localparam int OPW   = 18;
    localparam int VW    = 27;
    localparam int AW    = 26;
    localparam int ATW   = 22;
    localparam int SQW   = 32;
    localparam int ROOTW = 16;
    localparam int REMW  = 17;
    localparam int TW    = 15;
    localparam int ANGW  = 16;
    localparam int ADW   = 3;
    localparam int DW    = 32;

    localparam logic signed [AW-1:0] ACC_QUARTER = AW'(4194304);
    localparam logic signed [AW-1:0] ACC_HALF    = AW'(8388608);
    localparam logic signed [AW-1:0] ACC_THREEQ  = AW'(12582912);
    localparam logic signed [AW-1:0] ACC_RND     = AW'(128);

    localparam logic [TW-1:0]   THR_RESET  = TW'(3);
    localparam logic [ANGW-1:0] AZI_RESET  = ANGW'(16384);
    localparam logic [ANGW-1:0] ANG_HALF   = ANGW'(32768);
    localparam logic [ADW-1:0]  REG_THRESH = ADW'(0);

    // program addresses
    localparam logic [PCW-1:0] P_IDLE    = PCW'(0);
    localparam logic [PCW-1:0] P_SQX     = PCW'(1);
    localparam logic [PCW-1:0] P_SQZ     = PCW'(2);
    localparam logic [PCW-1:0] P_LOOP1   = PCW'(3);
    localparam logic [PCW-1:0] P_AZ_DONE = PCW'(4);
    localparam logic [PCW-1:0] P_ZE_INIT = PCW'(5);
    localparam logic [PCW-1:0] P_ZE_ITER = PCW'(6);
    localparam logic [PCW-1:0] P_ZE_DONE = PCW'(7);
    localparam logic [PCW-1:0] P_EMIT    = PCW'(8);
    localparam logic [PCW-1:0] P_LAST    = P_EMIT;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_NO_IN,
        JC_LOOP1,
        JC_SPECIAL,
        JC_CORDIC,
        JC_OUT_BUSY
    } t_jc;

    typedef struct packed {
        logic           ld_in;
        logic           sq_first;
        logic           sq_acc;
        logic           sqrt_en;
        logic           c_init;
        logic           c_iter;
        logic           pass_ze;
        logic           iter_clr;
        logic           iter_inc;
        logic           az_save;
        logic           ze_save;
        logic           emit;
        t_jc            jc;
        logic [PCW-1:0] target;
    } t_uword;

    function automatic t_uword f_ucode(input logic [PCW-1:0] pc);
        t_uword w;
        w        = '0;
        w.jc     = JC_NONE;
        w.target = P_IDLE;
        case (pc)
            P_IDLE: begin
                w.ld_in  = 1'b1;
                w.jc     = JC_NO_IN;
                w.target = P_IDLE;
            end
            P_SQX: begin
                w.sq_first = 1'b1;
            end
            P_SQZ: begin
                w.sq_acc   = 1'b1;
                w.c_init   = 1'b1;
                w.iter_clr = 1'b1;
            end
            P_LOOP1: begin
                w.sqrt_en  = 1'b1;
                w.c_iter   = 1'b1;
                w.iter_inc = 1'b1;
                w.jc       = JC_LOOP1;
                w.target   = P_LOOP1;
            end
            P_AZ_DONE: begin
                w.az_save = 1'b1;
            end
            P_ZE_INIT: begin
                w.c_init   = 1'b1;
                w.pass_ze  = 1'b1;
                w.iter_clr = 1'b1;
                w.jc       = JC_SPECIAL;
                w.target   = P_ZE_DONE;
            end
            P_ZE_ITER: begin
                w.c_iter   = 1'b1;
                w.iter_inc = 1'b1;
                w.jc       = JC_CORDIC;
                w.target   = P_ZE_ITER;
            end
            P_ZE_DONE: begin
                w.ze_save = 1'b1;
            end
            P_EMIT: begin
                w.emit   = 1'b1;
                w.jc     = JC_OUT_BUSY;
                w.target = P_EMIT;
            end
            default: begin
                w.jc = JC_NONE;
            end
        endcase
        return w;
    endfunction

    // atan(2^-i) in 2^-24 turns
    function automatic logic [ATW-1:0] f_atan(input logic [IW-1:0] idx);
        logic [ATW-1:0] v;
        case (idx)
            5'd0:    v = ATW'(2097152);
            5'd1:    v = ATW'(1238021);
            5'd2:    v = ATW'(654136);
            5'd3:    v = ATW'(332050);
            5'd4:    v = ATW'(166669);
            5'd5:    v = ATW'(83416);
            5'd6:    v = ATW'(41718);
            5'd7:    v = ATW'(20860);
            5'd8:    v = ATW'(10430);
            5'd9:    v = ATW'(5215);
            5'd10:   v = ATW'(2608);
            5'd11:   v = ATW'(1304);
            5'd12:   v = ATW'(652);
            5'd13:   v = ATW'(326);
            5'd14:   v = ATW'(163);
            5'd15:   v = ATW'(81);
            5'd16:   v = ATW'(41);
            5'd17:   v = ATW'(20);
            5'd18:   v = ATW'(10);
            5'd19:   v = ATW'(5);
            5'd20:   v = ATW'(3);
            5'd21:   v = ATW'(1);
            5'd22:   v = ATW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dtaz_if.sv
// ----------------------------------------------------------------------------
// dtaz_if
// valid/ready channels for direction words and angle words
// ----------------------------------------------------------------------------
`default_nettype none

interface dtaz_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface dtaz_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] zenith_angle;
    logic [15:0] azimuth_angle;
    logic        azimuth_held;

    modport source (output valid, output zenith_angle, output azimuth_angle,
                    output azimuth_held, input ready);
    modport sink   (input valid, input zenith_angle, input azimuth_angle,
                    input azimuth_held, output ready);
endinterface

`default_nettype wire

>>> rtl/core/direction_to_azimuth_zenith_core.sv
// ----------------------------------------------------------------------------
// direction_to_azimuth_zenith_core
// sequence: an accepted word runs the 16-step sqrt/azimuth cordic loop, then
//   the 16-step zenith cordic loop, skipped for an exact-axis zenith
// one word at a time: i_in.ready is high only while the sequencer is idle, and
//   the program waits at P_EMIT while the output holds an untaken word
// reset: synchronous, threshold back to 3, held azimuth back to a quarter turn
// microcoded sequencer over a shared multiplier, bit-pair sqrt and cordic unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "direction_to_azimuth_zenith_core_macros.svh"

module direction_to_azimuth_zenith_core
    import dtaz_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    dtaz_in_if.sink             i_in,
    dtaz_out_if.source          o_out,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [ADW-1:0] paddr,
    input  wire logic [DW-1:0]  pwdata,
    output logic      [DW-1:0]  prdata,
    output logic                pready
);

    // control state
    logic [PCW-1:0]  r_pc, n_pc;
    logic [IW-1:0]   r_iter, n_iter;
    logic            r_out_valid, n_out_valid;
    logic [TW-1:0]   r_thr, n_thr;
    logic [ANGW-1:0] r_last_az, n_last_az;

    // datapath
    logic signed [INW-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic [SQW-1:0]        r_sq, n_sq;
    logic [REMW-1:0]       r_rem, n_rem;
    logic [ROOTW-1:0]      r_root, n_root;
    logic signed [VW-1:0]  r_vx, n_vx, r_vy, n_vy;
    logic signed [AW-1:0]  r_acc, n_acc;
    logic                  r_special, n_special;
    logic [ANGW-1:0]       r_zen, n_zen, r_azi, n_azi;
    logic                  r_held, n_held;
    logic [ANGW-1:0]       r_out_zen, n_out_zen, r_out_azi, n_out_azi;
    logic                  r_out_held, n_out_held;

    t_uword cw;
    logic   in_fire, emit_fire, take;

    logic signed [INW-1:0]   mul_op;
    logic signed [2*INW-1:0] prod;

    logic [REMW+1:0] rem_t, trial;
    logic            sqrt_run;

    logic signed [OPW-1:0] op_yy, op_xx;
    logic signed [VW-1:0]  sx, sy, init_vx, init_vy;
    logic signed [AW-1:0]  init_acc;
    logic                  init_special;

    logic                  cordic_run;
    logic signed [VW-1:0]  cs_dx, cs_dy;
    logic signed [AW-1:0]  cs_tab;

    logic signed [AW-1:0]  az_sum, ze_clamp, ze_sum;
    logic [ANGW-1:0]       az_angle;
    logic                  az_hold;

    assign cw        = f_ucode(r_pc);
    assign in_fire   = i_in.valid && i_in.ready;
    assign emit_fire = cw.emit && (!r_out_valid || o_out.ready);

    assign i_in.ready          = (r_pc == P_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.zenith_angle  = r_out_zen;
    assign o_out.azimuth_angle = r_out_azi;
    assign o_out.azimuth_held  = r_out_held;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESH[2]) ? DW'(r_thr) : '0;

    // shared squaring multiplier
    assign mul_op = cw.sq_first ? r_x : r_z;
    assign prod   = mul_op * mul_op;

    // bit-pair square root
    assign sqrt_run = cw.sqrt_en && (r_iter < IW'(SQRT_STEPS));
    assign rem_t    = {r_rem, r_sq[SQW-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};

    // cordic operand select and exact-axis handling
    always_comb begin
        op_yy = cw.pass_ze ? $signed({2'b00, r_root}) : OPW'(r_x);
        op_xx = cw.pass_ze ? -OPW'(r_y) : OPW'(r_z);
        sy    = VW'(op_yy) <<< GUARD;
        sx    = VW'(op_xx) <<< GUARD;
    end

    always_comb begin
        init_vx      = sx;
        init_vy      = sy;
        init_acc     = '0;
        init_special = 1'b0;
        if (op_yy == '0) begin
            init_special = 1'b1;
            if (cw.pass_ze && (op_xx == '0)) begin
                init_acc = ACC_QUARTER;
            end else if (op_xx[OPW-1]) begin
                init_acc = ACC_HALF;
            end
        end else if (op_xx == '0) begin
            init_special = 1'b1;
            init_acc     = op_yy[OPW-1] ? ACC_THREEQ : ACC_QUARTER;
        end else if (sx[VW-1]) begin
            if (!sy[VW-1]) begin
                init_vx  = sy;
                init_vy  = -sx;
                init_acc = ACC_QUARTER;
            end else begin
                init_vx  = -sy;
                init_vy  = sx;
                init_acc = -ACC_QUARTER;
            end
        end
    end

    // cordic vectoring step
    assign cordic_run = cw.c_iter && !r_special && (r_iter < IW'(CORDIC_STEPS));
    assign cs_dx      = r_vy >>> r_iter;
    assign cs_dy      = r_vx >>> r_iter;
    assign cs_tab     = AW'(f_atan(r_iter));

    // rounding, clamp and hold decision
    always_comb begin
        az_sum   = r_acc + ACC_RND;
        az_angle = az_sum[GUARD +: ANGW];
        az_hold  = (r_root < ROOTW'(r_thr));
        if (r_acc[AW-1]) begin
            ze_clamp = '0;
        end else if (r_acc > ACC_HALF) begin
            ze_clamp = ACC_HALF;
        end else begin
            ze_clamp = r_acc;
        end
        ze_sum = ze_clamp + ACC_RND;
    end

    // sequencer
    always_comb begin
        case (cw.jc)
            JC_NONE:     take = 1'b0;
            JC_NO_IN:    take = !in_fire;
            JC_LOOP1:    take = (r_iter != IW'(LOOP1_LAST));
            JC_SPECIAL:  take = init_special;
            JC_CORDIC:   take = (r_iter != IW'(CORDIC_STEPS - 1));
            JC_OUT_BUSY: take = r_out_valid && !o_out.ready;
            default:     take = 1'b0;
        endcase
        if (take) begin
            n_pc = cw.target;
        end else if (r_pc == P_LAST) begin
            n_pc = P_IDLE;
        end else begin
            n_pc = r_pc + PCW'(1);
        end
    end

    always_comb begin
        n_iter = r_iter;
        if (cw.iter_clr) begin
            n_iter = '0;
        end else if (cw.iter_inc) begin
            n_iter = r_iter + IW'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_zen   = r_out_zen;
        n_out_azi   = r_out_azi;
        n_out_held  = r_out_held;
        if (emit_fire) begin
            n_out_valid = 1'b1;
            n_out_zen   = r_zen;
            n_out_azi   = r_azi;
            n_out_held  = r_held;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_thr = r_thr;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESH[2])) begin
            n_thr = pwdata[TW-1:0];
        end
    end

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (cw.ld_in && in_fire) begin
            n_x = i_in.dir_x;
            n_y = i_in.dir_y;
            n_z = i_in.dir_z;
        end
    end

    always_comb begin
        n_sq   = r_sq;
        n_rem  = r_rem;
        n_root = r_root;
        if (cw.sq_first) begin
            n_sq = SQW'(prod);
        end else if (cw.sq_acc) begin
            n_sq   = r_sq + SQW'(prod);
            n_rem  = '0;
            n_root = '0;
        end else if (sqrt_run) begin
            n_sq = r_sq << 2;
            if (rem_t >= trial) begin
                n_rem  = REMW'(rem_t - trial);
                n_root = {r_root[ROOTW-2:0], 1'b1};
            end else begin
                n_rem  = REMW'(rem_t);
                n_root = {r_root[ROOTW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_vx      = r_vx;
        n_vy      = r_vy;
        n_acc     = r_acc;
        n_special = r_special;
        if (cw.c_init) begin
            n_vx      = init_vx;
            n_vy      = init_vy;
            n_acc     = init_acc;
            n_special = init_special;
        end else if (cordic_run) begin
            if (!r_vy[VW-1]) begin
                n_vx  = r_vx + cs_dx;
                n_vy  = r_vy - cs_dy;
                n_acc = r_acc + cs_tab;
            end else begin
                n_vx  = r_vx - cs_dx;
                n_vy  = r_vy + cs_dy;
                n_acc = r_acc - cs_tab;
            end
        end
    end

    always_comb begin
        n_zen     = r_zen;
        n_azi     = r_azi;
        n_held    = r_held;
        n_last_az = r_last_az;
        if (cw.az_save) begin
            n_held = az_hold;
            if (az_hold) begin
                n_azi = r_last_az;
            end else begin
                n_azi     = az_angle;
                n_last_az = az_angle;
            end
        end
        if (cw.ze_save) begin
            n_zen = ze_sum[GUARD +: ANGW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= P_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
            r_last_az   <= AZI_RESET;
        end else begin
            r_pc        <= n_pc;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
            r_thr       <= n_thr;
            r_last_az   <= n_last_az;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_sq       <= n_sq;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_acc      <= n_acc;
        r_special  <= n_special;
        r_zen      <= n_zen;
        r_azi      <= n_azi;
        r_held     <= n_held;
        r_out_zen  <= n_out_zen;
        r_out_azi  <= n_out_azi;
        r_out_held <= n_out_held;
    end

    `DTAZ_ASSERT_NOW(a_zen_bound, o_out.valid, o_out.zenith_angle <= ANG_HALF, "zenith above half turn")
    `DTAZ_ASSERT_NEXT(a_accept_start, i_in.valid && i_in.ready, r_pc == P_SQX, "accepted word did not start program")
    `DTAZ_ASSERT_NOW(a_loop_range, r_pc == P_LOOP1 || r_pc == P_ZE_ITER, r_iter <= IW'(LOOP1_LAST), "step counter out of range")
    `DTAZ_ASSERT_NEXT(a_emit_done, r_pc == P_EMIT && (!r_out_valid || o_out.ready), r_out_valid && r_pc == P_IDLE, "result word not delivered")

endmodule

`default_nettype wire

>>> bench/direction_to_azimuth_zenith_core_tb.sv
// ----------------------------------------------------------------------------
// direction_to_azimuth_zenith_core_tb
// drives direction words through the core and compares every angle word with
// a bit-exact cordic predictor or a fixed row value; a directed table of axes,
// extremes and hold cases comes first, then random phases under several hold
// thresholds, bursty input, random output stalls and one long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module direction_to_azimuth_zenith_core_tb;
    import dtaz_pkg::*;

    localparam longint T_QUARTER = 64'sd4194304;
    localparam longint T_HALF    = 64'sd8388608;
    localparam longint T_THREEQ  = 64'sd12582912;
    localparam int     N_ROWS    = 24;
    localparam int     N_PHASES  = 6;
    localparam int     PHASE_LEN = 75;
    localparam int     HOLD_OFF  = 400;

    localparam longint ATAN_TURNS [0:23] = '{
        64'sd2097152, 64'sd1238021, 64'sd654136, 64'sd332050, 64'sd166669,
        64'sd83416, 64'sd41718, 64'sd20860, 64'sd10430, 64'sd5215,
        64'sd2608, 64'sd1304, 64'sd652, 64'sd326, 64'sd163, 64'sd81,
        64'sd41, 64'sd20, 64'sd10, 64'sd5, 64'sd3, 64'sd1, 64'sd1, 64'sd0
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_dir_word;

    typedef struct packed {
        logic [ANGW-1:0] zenith;
        logic [ANGW-1:0] azimuth;
        logic            held;
    } t_angle_word;

    typedef struct packed {
        logic               wr_thr;
        logic [TW-1:0]      thr;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               known;
        logic [ANGW-1:0]    zen;
        logic [ANGW-1:0]    azi;
        logic               held;
    } t_stim_row;

    // axes, extremes, hold boundary, zero vector, zero and max threshold
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{1'b0, 15'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd16384, 16'd16384, 1'b1},
        '{1'b0, 15'd0, 16'sd0, 16'sd32767, 16'sd0, 1'b1, 16'd32768, 16'd16384, 1'b1},
        '{1'b0, 15'd0, 16'sd0, 16'sh8000, 16'sd0, 1'b1, 16'd0, 16'd16384, 1'b1},
        '{1'b0, 15'd0, 16'sd2, 16'sd0, 16'sd2, 1'b1, 16'd16384, 16'd16384, 1'b1},
        '{1'b0, 15'd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1, 16'd16384, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sd1, 16'sd0, 16'sd1, 1'b1, 16'd16384, 16'd0, 1'b1},
        '{1'b0, 15'd0, 16'sd32767, 16'sd0, 16'sd0, 1'b1, 16'd16384, 16'd16384, 1'b0},
        '{1'b0, 15'd0, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 16'd16384, 16'd49152, 1'b0},
        '{1'b0, 15'd0, 16'sd0, 16'sd0, 16'sh8000, 1'b1, 16'd16384, 16'd32768, 1'b0},
        '{1'b0, 15'd0, 16'sd3, 16'sd0, 16'sd0, 1'b1, 16'd16384, 16'd16384, 1'b0},
        '{1'b0, 15'd0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sd23170, 16'sd0, 16'sd23170, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, -16'sd23170, 16'sd0, -16'sd23170, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sh8000, 16'sd32767, 16'sd1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sd1, -16'sd1, -16'sd1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sd12000, -16'sd28000, -16'sd9000, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, -16'sd5, 16'sd32767, 16'sd7, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 15'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd16384, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sd0, 16'sh8000, 16'sd0, 1'b1, 16'd0, 16'd0, 1'b0},
        '{1'b1, 15'd32767, 16'sh8000, 16'sd0, 16'sh8000, 1'b0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 15'd0, 16'sd32767, 16'sd0, 16'sd0, 1'b1, 16'd16384, 16'd16384, 1'b0},
        '{1'b0, 15'd0, 16'sd32766, 16'sd0, 16'sd0, 1'b1, 16'd16384, 16'd16384, 1'b1},
        '{1'b1, 15'd3, 16'sd0, 16'sd1, 16'sd0, 1'b1, 16'd32768, 16'd16384, 1'b1}
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [ADW-1:0] paddr;
    logic [DW-1:0] pwdata;
    logic [DW-1:0] prdata;
    logic          pready;

    dtaz_in_if  dir_ch ();
    dtaz_out_if ang_ch ();

    direction_to_azimuth_zenith_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (dir_ch),
        .o_out   (ang_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_angle_word   pending_angles [$];
    t_angle_word   head_angle;
    logic [TW-1:0] hold_threshold;
    logic [ANGW-1:0] held_heading;
    int            mismatch_count = 0;
    int            burst_left = 8;
    logic          hold_off_now = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint isqrt_floor(input longint v);
        longint res;
        longint step_bit;
        res = 0;
        step_bit = 64'sd1 <<< 62;
        while (step_bit > v) step_bit = step_bit >>> 2;
        while (step_bit != 0) begin
            if (v >= res + step_bit) begin
                v = v - (res + step_bit);
                res = (res >>> 1) + step_bit;
            end else begin
                res = res >>> 1;
            end
            step_bit = step_bit >>> 2;
        end
        return res;
    endfunction

    // atan2(yy, xx) in 2^-24 turns, unwrapped
    function automatic longint turns_atan2(input longint yy, input longint xx);
        longint cx, cy, acc, t, dx, dy;
        int i;
        if (yy == 0) return (xx < 0) ? T_HALF : 64'sd0;
        if (xx == 0) return (yy > 0) ? T_QUARTER : T_THREEQ;
        cx = xx * 256;
        cy = yy * 256;
        acc = 0;
        if (cx < 0) begin
            t = cx;
            if (cy >= 0) begin
                cx = cy;
                cy = -t;
                acc = T_QUARTER;
            end else begin
                cx = -cy;
                cy = t;
                acc = -T_QUARTER;
            end
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx = cx + dx;
                cy = cy - dy;
                acc = acc + ATAN_TURNS[i];
            end else begin
                cx = cx - dx;
                cy = cy + dy;
                acc = acc - ATAN_TURNS[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [ANGW-1:0] round_turns(input longint a);
        return ANGW'((a + 128) >>> GUARD);
    endfunction

    function automatic t_angle_word azimuth_zenith_of(input t_dir_word d);
        t_angle_word w;
        longint x, y, z, h, a;
        x = d.x;
        y = d.y;
        z = d.z;
        h = isqrt_floor(x * x + z * z);
        if (h == 0 && y == 0) begin
            w.zenith = ANGW'(16384);
        end else begin
            a = turns_atan2(h, -y);
            if (a < 0) a = 0;
            if (a > T_HALF) a = T_HALF;
            w.zenith = round_turns(a);
        end
        if (h < longint'(hold_threshold)) begin
            w.azimuth = held_heading;
            w.held = 1'b1;
        end else begin
            w.azimuth = round_turns(turns_atan2(x, z));
            held_heading = w.azimuth;
            w.held = 1'b0;
        end
        return w;
    endfunction

    function automatic t_dir_word random_dir();
        t_dir_word d;
        int kind, mask, a, b;
        longint rem;
        kind = $urandom_range(0, 9);
        d.x = 16'($urandom);
        d.y = 16'($urandom);
        d.z = 16'($urandom);
        if (kind >= 3 && kind <= 5) begin
            // close to unit length
            a = int'($urandom_range(0, 46000)) - 23000;
            b = int'($urandom_range(0, 46000)) - 23000;
            rem = 64'sd1073676289 - longint'(a) * a - longint'(b) * b;
            d.x = 16'(a);
            d.z = 16'(b);
            d.y = 16'(int'($floor($sqrt(real'(rem)))));
            if ($urandom_range(0, 1) == 1) d.y = -d.y;
        end else if (kind == 6 || kind == 7) begin
            // near vertical, hold region
            d.x = 16'(int'($urandom_range(0, 12)) - 6);
            d.z = 16'(int'($urandom_range(0, 12)) - 6);
            if ($urandom_range(0, 7) == 0) begin
                d.y = 16'sh8000;
            end else begin
                d.y = 16'($urandom_range(20000, 32767));
                if ($urandom_range(0, 1) == 1) d.y = -d.y;
            end
        end else if (kind == 8) begin
            mask = $urandom_range(1, 6);
            if (mask[0]) d.x = '0;
            if (mask[1]) d.y = '0;
            if (mask[2]) d.z = '0;
        end else if (kind == 9) begin
            d.x = 16'(int'($urandom_range(0, 8)) - 4);
            d.y = 16'(int'($urandom_range(0, 8)) - 4);
            d.z = 16'(int'($urandom_range(0, 8)) - 4);
        end
        return d;
    endfunction

    task automatic apb_xfer(input logic wr, input logic [ADW-1:0] addr,
                            input logic [DW-1:0] wdata, output logic [DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [TW-1:0] thr);
        logic [DW-1:0] rd;
        dir_ch.valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        apb_xfer(1'b1, REG_THRESH, DW'(thr), rd);
        apb_xfer(1'b0, REG_THRESH, '0, rd);
        if (rd[TW-1:0] !== thr) begin
            $error("degenerate_threshold: expected %0d, got %0d", thr, rd[TW-1:0]);
            mismatch_count++;
        end
        hold_threshold = thr;
    endtask

    task automatic offer_dir(input t_dir_word d, input logic known, input t_angle_word fixed);
        t_angle_word pred;
        dir_ch.valid <= 1'b1;
        dir_ch.dir_x <= d.x;
        dir_ch.dir_y <= d.y;
        dir_ch.dir_z <= d.z;
        do @(posedge i_clk); while (!dir_ch.ready);
        pred = azimuth_zenith_of(d);
        pending_angles.push_back(known ? fixed : pred);
        if (burst_left == 0) begin
            dir_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
    endtask

    // output stalls
    initial begin
        int span;
        int ready_mode;
        ang_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_now) begin
                hold_off_now = 1'b0;
                ang_ch.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end else begin
                span = $urandom_range(1, 60);
                ready_mode = $urandom_range(0, 3);
                repeat (span) begin
                    case (ready_mode)
                        0, 1: ang_ch.ready <= 1'b1;
                        2: ang_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: ang_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ang_ch.valid && ang_ch.ready) begin
            if (pending_angles.size() == 0) begin
                $error("angle word with none pending");
                mismatch_count++;
            end else begin
                head_angle = pending_angles.pop_front();
                if (ang_ch.zenith_angle !== head_angle.zenith) begin
                    $error("zenith_angle: expected %0d, got %0d",
                           head_angle.zenith, ang_ch.zenith_angle);
                    mismatch_count++;
                end
                if (ang_ch.azimuth_angle !== head_angle.azimuth) begin
                    $error("azimuth_angle: expected %0d, got %0d",
                           head_angle.azimuth, ang_ch.azimuth_angle);
                    mismatch_count++;
                end
                if (ang_ch.azimuth_held !== head_angle.held) begin
                    $error("azimuth_held: expected %0d, got %0d",
                           head_angle.held, ang_ch.azimuth_held);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_dir_word     d;
        t_angle_word   k;
        logic [TW-1:0] thr;
        i_rst_n      <= 1'b0;
        dir_ch.valid <= 1'b0;
        dir_ch.dir_x <= '0;
        dir_ch.dir_y <= '0;
        dir_ch.dir_z <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        hold_threshold = THR_RESET;
        held_heading   = AZI_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED_ROWS[r].wr_thr) set_threshold(DIRECTED_ROWS[r].thr);
            d = '{DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].z};
            k = '{DIRECTED_ROWS[r].zen, DIRECTED_ROWS[r].azi, DIRECTED_ROWS[r].held};
            offer_dir(d, DIRECTED_ROWS[r].known, k);
        end

        k = '0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: thr = '0;
                1: thr = '1;
                2: thr = TW'($urandom_range(0, 15));
                3: thr = TW'($urandom);
                4: thr = TW'($urandom_range(1, 400));
                default: thr = THR_RESET;
            endcase
            set_threshold(thr);
            // long output hold-off while words keep coming
            if (ph == 2) hold_off_now = 1'b1;
            repeat (PHASE_LEN) begin
                d = random_dir();
                offer_dir(d, 1'b0, k);
            end
        end

        dir_ch.valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> direction_to_azimuth_zenith_core.f
+incdir+rtl/core
rtl/core/dtaz_pkg.sv
rtl/core/dtaz_if.sv
rtl/core/direction_to_azimuth_zenith_core.sv
bench/direction_to_azimuth_zenith_core_tb.sv
